>>> src/ibfp_pkg.sv
`timescale 1ns / 1ps

package ibfp_pkg;

   // Byte slots of one word's output run, in emission order
   typedef enum logic [2:0] {
      SLOT_STREAM,
      SLOT_START,
      SLOT_SIZE,
      SLOT_ADDR,
      SLOT_CONTROL,
      SLOT_DATA,
      SLOT_STOP,
      SLOT_TERM
   } slot_type;

   localparam int unsigned SLOT_COUNT = 8;

   // Fixed bytes of the bridge packet stream
   localparam logic [7:0] BYTE_STREAM    = 8'hAA;
   localparam logic [7:0] BYTE_START     = 8'h74;
   localparam logic [7:0] BYTE_SIZE_FLAG = 8'h80;
   localparam logic [7:0] BYTE_CONTROL   = 8'h40;
   localparam logic [7:0] BYTE_STOP      = 8'h75;
   localparam logic [7:0] BYTE_TERM      = 8'h00;

   // Register map
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH  = 12;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDRESS = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_LENGTH   = 8'd1;

   // One word's output run, as handed from the input stage to the serializer
   typedef struct packed {
      logic [SLOT_COUNT-1:0] slot_mask;
      logic [7:0]            size_byte;
      logic [7:0]            addr_byte;
      logic [7:0]            data_byte;
   } plan_type;

endpackage

>>> src/ibfp_ifs.sv
`timescale 1ns / 1ps

// Frame byte channel
interface ibfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// Packet stream channel
interface ibfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] usb_byte;
   logic       packet_end;
   logic       run_last;

   modport source (output valid, output usb_byte, output packet_end, output run_last,
                   input ready);
   modport sink   (input valid, input usb_byte, input packet_end, input run_last,
                   output ready);
endinterface

// Register write channel
interface ibfp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ibfp_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [ibfp_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/i2c_bridge_frame_packetizer_core.sv
`timescale 1ns / 1ps

// Bridge frame packetizer.
// req_bus takes display frame bytes one word at a time; rsp_bus returns the
// bridge packet stream one byte per word, with packet_end on each packet's
// terminator and run_last on the final byte caused by an input word.
// csr_bus writes device_address (index 0) and frame_length (index 1); it is
// always ready, and unknown indexes are dropped. Both are sampled at the
// start of each frame.
// A word accepted on req_bus is held in the input register until the output
// stage loads it; its bytes then go out on rsp_bus from the output stage.
// Throughput: one output byte per cycle while rsp_bus is ready. A word emits
// 1 to 8 bytes (a frame opener adds 5, a packet opener 2, a packet close 1 or
// 2), all sent one after another on the single output byte lane.
// Reset sets device_address to 60, frame_length to 512 and makes the next
// word open a frame. When rsp_bus stalls, the current byte holds, one more
// word waits in the input register, and then req_bus.ready drops.
module i2c_bridge_frame_packetizer_core #(
   parameter int unsigned PACKET_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   ibfp_req_if.sink   req_bus,
   ibfp_rsp_if.source rsp_bus,
   ibfp_csr_if.sink   csr_bus
);

   localparam int unsigned FIRST_CAP = PACKET_LEN - 6;
   localparam int unsigned LATER_CAP = PACKET_LEN - 3;

   logic [6:0]  dev_addr_ff,  dev_addr_in;
   logic [11:0] frame_len_ff, frame_len_in;
   logic [11:0] rem_ff,       rem_in;
   logic [5:0]  left_ff,      left_in;
   logic        first_ff,     first_in;
   logic        s1_valid_ff,  s1_valid_in;
   ibfp_pkg::plan_type s1_plan_ff, s1_plan_in;

   logic        load_ready;
   logic        req_fire;
   logic [11:0] len_eff, rem_eff, rem_load, rem_dec;
   logic [5:0]  n_first, n_later, left_load, left_dec;
   logic        hdr_new, frame_done, pkt_done;
   ibfp_pkg::plan_type plan_new;

   // Register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      dev_addr_in  = dev_addr_ff;
      frame_len_in = frame_len_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            ibfp_pkg::CSR_DEVICE_ADDRESS: dev_addr_in  = csr_bus.data[6:0];
            ibfp_pkg::CSR_FRAME_LENGTH:   frame_len_in = csr_bus.data[11:0];
            default: ;
         endcase
      end
   end

   // Packet bookkeeping for the word being accepted
   always_comb begin
      len_eff = (frame_len_ff == '0) ? 12'd1 : frame_len_ff;
      rem_eff = (rem_ff == '0) ? 12'd1 : rem_ff;
      n_first = (len_eff < 12'(FIRST_CAP)) ? len_eff[5:0] : 6'(FIRST_CAP);
      n_later = (rem_eff < 12'(LATER_CAP)) ? rem_eff[5:0] : 6'(LATER_CAP);
      hdr_new = !first_ff && ((left_ff == '0) || (rem_ff == '0));

      if (first_ff) begin
         rem_load  = len_eff;
         left_load = n_first;
      end else if (hdr_new) begin
         rem_load  = rem_eff;
         left_load = n_later;
      end else begin
         rem_load  = rem_ff;
         left_load = left_ff;
      end

      rem_dec    = rem_load - 12'd1;
      left_dec   = left_load - 6'd1;
      frame_done = (rem_dec == '0);
      pkt_done   = (left_dec == '0) || frame_done;

      plan_new.slot_mask = '0;
      plan_new.slot_mask[ibfp_pkg::SLOT_STREAM]  = first_ff || hdr_new;
      plan_new.slot_mask[ibfp_pkg::SLOT_START]   = first_ff;
      plan_new.slot_mask[ibfp_pkg::SLOT_SIZE]    = first_ff || hdr_new;
      plan_new.slot_mask[ibfp_pkg::SLOT_ADDR]    = first_ff;
      plan_new.slot_mask[ibfp_pkg::SLOT_CONTROL] = first_ff;
      plan_new.slot_mask[ibfp_pkg::SLOT_DATA]    = 1'b1;
      plan_new.slot_mask[ibfp_pkg::SLOT_STOP]    = frame_done;
      plan_new.slot_mask[ibfp_pkg::SLOT_TERM]    = pkt_done;
      plan_new.size_byte = first_ff
         ? (ibfp_pkg::BYTE_SIZE_FLAG | {2'b00, n_first + 6'd2})
         : (ibfp_pkg::BYTE_SIZE_FLAG | {2'b00, n_later});
      plan_new.addr_byte = {dev_addr_ff, 1'b0};
      plan_new.data_byte = req_bus.data_byte;
   end

   // Input register, refilled while the output stage drains
   assign req_bus.ready = !s1_valid_ff || load_ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      rem_in      = rem_ff;
      left_in     = left_ff;
      first_in    = first_ff;
      s1_valid_in = s1_valid_ff;
      s1_plan_in  = s1_plan_ff;
      if (req_fire) begin
         rem_in      = rem_dec;
         left_in     = frame_done ? 6'd0 : left_dec;
         first_in    = frame_done;
         s1_valid_in = 1'b1;
         s1_plan_in  = plan_new;
      end else if (load_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= 7'd60;
         frame_len_ff <= 12'd512;
         rem_ff       <= '0;
         left_ff      <= '0;
         first_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
      end else begin
         dev_addr_ff  <= dev_addr_in;
         frame_len_ff <= frame_len_in;
         rem_ff       <= rem_in;
         left_ff      <= left_in;
         first_ff     <= first_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_plan_ff <= s1_plan_in;
   end

   // Output stage
   ibfp_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff),
      .load_ready (load_ready),
      .load_plan  (s1_plan_ff),
      .rsp_bus    (rsp_bus)
   );

   // Word still waiting in the input register is kept
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !load_ready) |=> s1_valid_ff && $stable(s1_plan_ff))
      else $error("input register lost a waiting word");

   // A finished frame always ends its packet
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (req_fire && frame_done) |-> pkt_done)
      else $error("frame ended without closing its packet");

   // Inside a frame the packet count never runs past the frame count
   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      !first_ff |-> ({6'd0, left_ff} <= rem_ff))
      else $error("packet count exceeds remaining frame bytes");

endmodule

>>> src/ibfp_serializer.sv
`timescale 1ns / 1ps

module ibfp_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_valid,
   output logic               load_ready,
   input  ibfp_pkg::plan_type load_plan,
   ibfp_rsp_if.source         rsp_bus
);

   logic [ibfp_pkg::SLOT_COUNT-1:0] mask_ff, mask_in;
   ibfp_pkg::plan_type              plan_ff, plan_in;
   ibfp_pkg::slot_type              cur_slot;
   logic [ibfp_pkg::SLOT_COUNT-1:0] mask_rest;
   logic                            rsp_fire;
   logic                            load_fire;

   // Lowest pending slot goes out first
   always_comb begin
      cur_slot = ibfp_pkg::SLOT_TERM;
      for (int i = ibfp_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur_slot = ibfp_pkg::slot_type'(3'(i));
         end
      end
   end

   assign mask_rest  = mask_ff & (mask_ff - {{(ibfp_pkg::SLOT_COUNT-1){1'b0}}, 1'b1});
   assign rsp_fire   = rsp_bus.valid && rsp_bus.ready;
   assign load_ready = (mask_ff == '0) || (rsp_bus.ready && (mask_rest == '0));
   assign load_fire  = load_valid && load_ready;

   // Output byte select
   always_comb begin
      unique case (cur_slot)
         ibfp_pkg::SLOT_STREAM:  rsp_bus.usb_byte = ibfp_pkg::BYTE_STREAM;
         ibfp_pkg::SLOT_START:   rsp_bus.usb_byte = ibfp_pkg::BYTE_START;
         ibfp_pkg::SLOT_SIZE:    rsp_bus.usb_byte = plan_ff.size_byte;
         ibfp_pkg::SLOT_ADDR:    rsp_bus.usb_byte = plan_ff.addr_byte;
         ibfp_pkg::SLOT_CONTROL: rsp_bus.usb_byte = ibfp_pkg::BYTE_CONTROL;
         ibfp_pkg::SLOT_DATA:    rsp_bus.usb_byte = plan_ff.data_byte;
         ibfp_pkg::SLOT_STOP:    rsp_bus.usb_byte = ibfp_pkg::BYTE_STOP;
         ibfp_pkg::SLOT_TERM:    rsp_bus.usb_byte = ibfp_pkg::BYTE_TERM;
         default:                rsp_bus.usb_byte = ibfp_pkg::BYTE_TERM;
      endcase
   end

   assign rsp_bus.valid      = (mask_ff != '0);
   assign rsp_bus.packet_end = (cur_slot == ibfp_pkg::SLOT_TERM);
   assign rsp_bus.run_last   = (mask_rest == '0);

   // Next run loads as the current one drains
   always_comb begin
      mask_in = mask_ff;
      plan_in = plan_ff;
      if (load_fire) begin
         mask_in = load_plan.slot_mask;
         plan_in = load_plan;
      end else if (rsp_fire) begin
         mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

   // A loaded run always carries the frame byte
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> mask_ff[ibfp_pkg::SLOT_DATA] || $past(mask_ff) != '0)
      else $error("run loaded without its frame byte");

   // Stalled output keeps its pending slots
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> $stable(mask_ff))
      else $error("pending slots changed under stall");

   // A stop byte is always followed by a terminator
   a_stop_term: assert property (@(posedge clock) disable iff (reset)
      mask_ff[ibfp_pkg::SLOT_STOP] |-> mask_ff[ibfp_pkg::SLOT_TERM])
      else $error("stop byte without terminator");

endmodule
